@@ hw/rtl/neighbor_table_with_aging_unit_defines.svh @@
// assertion macros shared by the neighbour table rtl
`ifndef NEIGHBOR_TABLE_WITH_AGING_UNIT_DEFINES_SVH
`define NEIGHBOR_TABLE_WITH_AGING_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define NTA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define NTA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/nta_pkg.sv @@
// types and constants shared by the neighbour table cells and top level
package nta_pkg;

    localparam int DATA_W   = 32;
    localparam int SEL_W    = 4;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;
    localparam int OP_W     = 2;

    localparam logic [DATA_W-1:0] TIMEOUT_RESET = 32'd3000;

    typedef enum logic [OP_W-1:0] {
        OP_UPDATE = 2'd0,
        OP_SWEEP  = 2'd1,
        OP_READ   = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        PH_SEARCH = 2'd0,
        PH_WRITE  = 2'd1,
        PH_SWEEP  = 2'd2,
        PH_READ   = 2'd3
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_REFRESHED = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_DROPPED   = 3'd2,
        ST_SWEPT     = 3'd3,
        ST_READ      = 3'd4
    } status_t;

    typedef struct packed {
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] lat;
        logic [DATA_W-1:0] lon;
        logic [DATA_W-1:0] speed;
        logic [DATA_W-1:0] heading;
        logic [DATA_W-1:0] gps_time;
        logic [DATA_W-1:0] rx_tick;
    } slot_t;

    typedef struct packed {
        slot_t            rec;
        logic [SEL_W-1:0] sel;
    } item_t;

    typedef struct packed {
        logic               active;
        phase_t             phase;
        logic               hit;
        logic [SEL_W-1:0]   hit_idx;
        logic               free;
        logic [SEL_W-1:0]   free_idx;
        logic [COUNT_W-1:0] removed;
        logic               rd_valid;
        slot_t              rd;
    } probe_t;

endpackage

@@ hw/rtl/nta_cell.sv @@
// one table slot of the neighbour table, passing the probe on to the next slot
`include "neighbor_table_with_aging_unit_defines.svh"

module nta_cell #(
    parameter int SLOT_NUM = 0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [nta_pkg::DATA_W-1:0] timeout,
    input  nta_pkg::item_t             item,
    input  nta_pkg::probe_t            probe_in,
    output nta_pkg::probe_t            probe_out
);
    import nta_pkg::*;

    localparam logic [SEL_W-1:0] SLOT_LOW  = SEL_W'(SLOT_NUM);
    localparam bit               SEL_REACH = SLOT_NUM < (1 << SEL_W);

    logic              valid_reg;
    logic              valid_next;
    logic              hit_mark_reg;
    logic              hit_mark_next;
    logic              free_mark_reg;
    logic              free_mark_next;
    slot_t             rec_reg;
    logic              rec_we;
    probe_t            probe_reg;
    probe_t            probe_next;
    logic [DATA_W-1:0] age;
    logic              stale;
    logic              key_hit;
    logic              wr_sel;

    assign age     = item.rec.rx_tick - rec_reg.rx_tick;
    assign stale   = valid_reg && (age > timeout);
    assign key_hit = valid_reg && (rec_reg.key == item.rec.key);
    assign wr_sel  = probe_in.hit ? hit_mark_reg : free_mark_reg;

    always_comb
    begin
        probe_next     = probe_in;
        valid_next     = valid_reg;
        hit_mark_next  = hit_mark_reg;
        free_mark_next = free_mark_reg;
        rec_we         = 1'b0;
        if (probe_in.active)
        begin
            unique case (probe_in.phase)
                PH_SEARCH:
                begin
                    hit_mark_next  = key_hit && !probe_in.hit;
                    free_mark_next = !valid_reg && !probe_in.free;
                    if (key_hit && !probe_in.hit)
                    begin
                        probe_next.hit     = 1'b1;
                        probe_next.hit_idx = SLOT_LOW;
                    end
                    if (!valid_reg && !probe_in.free)
                    begin
                        probe_next.free     = 1'b1;
                        probe_next.free_idx = SLOT_LOW;
                    end
                end
                PH_WRITE:
                begin
                    if (wr_sel)
                    begin
                        rec_we     = 1'b1;
                        valid_next = 1'b1;
                    end
                end
                PH_SWEEP:
                begin
                    if (stale)
                    begin
                        valid_next         = 1'b0;
                        probe_next.removed = probe_in.removed + 1'b1;
                    end
                end
                PH_READ:
                begin
                    if (SEL_REACH && (item.sel == SLOT_LOW))
                    begin
                        probe_next.rd_valid = valid_reg;
                        probe_next.rd       = rec_reg;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            hit_mark_reg  <= 1'b0;
            free_mark_reg <= 1'b0;
            probe_reg     <= '0;
        end
        else
        begin
            valid_reg     <= valid_next;
            hit_mark_reg  <= hit_mark_next;
            free_mark_reg <= free_mark_next;
            probe_reg     <= probe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_we)
        begin
            rec_reg <= item.rec;
        end
    end

    assign probe_out = probe_reg;

    // a slot is never both the matching one and the free one
    `NTA_ASSERT_IMP(a_marks_exclusive, clk, rst_n, 1'b1, !(hit_mark_reg && free_mark_reg), "slot marked both hit and free")
    // the probe moves one cell per cycle
    `NTA_ASSERT_NXT(a_probe_hop, clk, rst_n, probe_in.active, probe_out.active, "probe lost in cell")
    // a sweep never revives an inactive slot
    `NTA_ASSERT_NXT(a_sweep_no_revive, clk, rst_n, probe_in.active && (probe_in.phase == PH_SWEEP) && !valid_reg, !valid_reg, "sweep set a slot valid")

endmodule

@@ hw/rtl/neighbor_table_with_aging_unit.sv @@
// neighbour table with aging: top level with sequencer and chain of slot cells
// An item walks the row of slots one slot per clock. A sweep or a read walks
// the row once before its result is registered; an update walks the row once
// to find a matching or free slot and once more to write it, and an update
// dropped on a full table returns after the first walk. Another item may be
// accepted while a result waits in the output register to be taken, but not
// while the sequencer is busy or still holds its result; an operation code of
// 3 is taken and dropped without a result.
`include "neighbor_table_with_aging_unit_defines.svh"

module neighbor_table_with_aging_unit #(
    parameter int TABLE_SLOTS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [nta_pkg::DATA_W-1:0]   cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [nta_pkg::OP_W-1:0]     operation,
    input  logic [nta_pkg::DATA_W-1:0]   vehicle_key,
    input  logic [nta_pkg::DATA_W-1:0]   lat_bits,
    input  logic [nta_pkg::DATA_W-1:0]   lon_bits,
    input  logic [nta_pkg::DATA_W-1:0]   speed_bits,
    input  logic [nta_pkg::DATA_W-1:0]   heading_bits,
    input  logic [nta_pkg::DATA_W-1:0]   gps_time_in,
    input  logic [nta_pkg::DATA_W-1:0]   now_tick,
    input  logic [nta_pkg::SEL_W-1:0]    slot_select,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [nta_pkg::STATUS_W-1:0] status,
    output logic [nta_pkg::SEL_W-1:0]    slot_index,
    output logic [nta_pkg::COUNT_W-1:0]  active_count,
    output logic [nta_pkg::COUNT_W-1:0]  removed_count,
    output logic                         read_valid,
    output logic [nta_pkg::DATA_W-1:0]   read_key,
    output logic [nta_pkg::DATA_W-1:0]   read_lat,
    output logic [nta_pkg::DATA_W-1:0]   read_lon,
    output logic [nta_pkg::DATA_W-1:0]   read_speed,
    output logic [nta_pkg::DATA_W-1:0]   read_heading,
    output logic [nta_pkg::DATA_W-1:0]   read_gps_time,
    output logic [nta_pkg::DATA_W-1:0]   read_rx_tick
);
    import nta_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_BUSY = 3'b010,
        S_WAIT = 3'b100
    } state_t;

    typedef struct packed {
        status_t            status;
        logic [SEL_W-1:0]   idx;
        logic [COUNT_W-1:0] count;
        logic [COUNT_W-1:0] removed;
        logic               rd_valid;
        slot_t              rd;
    } res_t;

    state_t             state_reg;
    state_t             state_next;
    logic [DATA_W-1:0]  timeout_reg;
    logic [DATA_W-1:0]  timeout_next;
    item_t              item_reg;
    item_t              item_next;
    probe_t             launch_reg;
    probe_t             launch_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    res_t               res_reg;
    res_t               res_next;
    res_t               out_reg;
    res_t               out_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               in_fire;
    logic               cfg_fire;
    logic               out_load;
    probe_t             chain [TABLE_SLOTS+1];
    probe_t             end_probe;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_load  = (state_reg == S_WAIT) && (!out_valid_reg || out_ready);

    assign chain[0]  = launch_reg;
    assign end_probe = chain[TABLE_SLOTS];

    for (genvar g = 0; g < TABLE_SLOTS; g++)
    begin : g_cell
        nta_cell #(
            .SLOT_NUM (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .timeout   (timeout_reg),
            .item      (item_reg),
            .probe_in  (chain[g]),
            .probe_out (chain[g+1])
        );
    end

    assign timeout_next = cfg_fire ? cfg_data : timeout_reg;

    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        launch_next = '0;
        count_next  = count_reg;
        res_next    = res_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    item_next.rec.key      = vehicle_key;
                    item_next.rec.lat      = lat_bits;
                    item_next.rec.lon      = lon_bits;
                    item_next.rec.speed    = speed_bits;
                    item_next.rec.heading  = heading_bits;
                    item_next.rec.gps_time = gps_time_in;
                    item_next.rec.rx_tick  = now_tick;
                    item_next.sel          = slot_select;
                    unique case (op_t'(operation))
                        OP_UPDATE:
                        begin
                            launch_next.active = 1'b1;
                            launch_next.phase  = PH_SEARCH;
                            state_next         = S_BUSY;
                        end
                        OP_SWEEP:
                        begin
                            launch_next.active = 1'b1;
                            launch_next.phase  = PH_SWEEP;
                            state_next         = S_BUSY;
                        end
                        OP_READ:
                        begin
                            launch_next.active = 1'b1;
                            launch_next.phase  = PH_READ;
                            state_next         = S_BUSY;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_BUSY:
            begin
                if (end_probe.active)
                begin
                    res_next = '0;
                    unique case (end_probe.phase)
                        PH_SEARCH:
                        begin
                            if (end_probe.hit || end_probe.free)
                            begin
                                launch_next       = end_probe;
                                launch_next.phase = PH_WRITE;
                            end
                            else
                            begin
                                res_next.status = ST_DROPPED;
                                res_next.count  = count_reg;
                                state_next      = S_WAIT;
                            end
                        end
                        PH_WRITE:
                        begin
                            if (end_probe.hit)
                            begin
                                res_next.status = ST_REFRESHED;
                                res_next.idx    = end_probe.hit_idx;
                            end
                            else
                            begin
                                count_next      = count_reg + 1'b1;
                                res_next.status = ST_INSERTED;
                                res_next.idx    = end_probe.free_idx;
                            end
                            res_next.count = count_next;
                            state_next     = S_WAIT;
                        end
                        PH_SWEEP:
                        begin
                            count_next       = count_reg - end_probe.removed;
                            res_next.status  = ST_SWEPT;
                            res_next.count   = count_next;
                            res_next.removed = end_probe.removed;
                            state_next       = S_WAIT;
                        end
                        PH_READ:
                        begin
                            res_next.status   = ST_READ;
                            res_next.idx      = item_reg.sel;
                            res_next.count    = count_reg;
                            res_next.rd_valid = end_probe.rd_valid;
                            res_next.rd       = end_probe.rd;
                            state_next        = S_WAIT;
                        end
                    endcase
                end
            end
            S_WAIT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_next       = res_reg;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            timeout_reg   <= TIMEOUT_RESET;
            launch_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            timeout_reg   <= timeout_next;
            launch_reg    <= launch_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_reg.status;
    assign slot_index    = out_reg.idx;
    assign active_count  = out_reg.count;
    assign removed_count = out_reg.removed;
    assign read_valid    = out_reg.rd_valid;
    assign read_key      = out_reg.rd.key;
    assign read_lat      = out_reg.rd.lat;
    assign read_lon      = out_reg.rd.lon;
    assign read_speed    = out_reg.rd.speed;
    assign read_heading  = out_reg.rd.heading;
    assign read_gps_time = out_reg.rd.gps_time;
    assign read_rx_tick  = out_reg.rd.rx_tick;

    // probes only travel while an item is being worked on
    `NTA_ASSERT_IMP(a_probe_in_busy, clk, rst_n, launch_reg.active || end_probe.active, state_reg == S_BUSY, "probe outside busy state")
    // a known operation starts a walk in the next cycle
    `NTA_ASSERT_NXT(a_op_starts, clk, rst_n, in_fire && ((operation == OP_UPDATE) || (operation == OP_SWEEP) || (operation == OP_READ)), launch_reg.active, "accepted item did not launch")
    // the result register is only refilled once its item has gone
    `NTA_ASSERT_NXT(a_out_no_overwrite, clk, rst_n, out_valid_reg && !out_ready, $stable(out_reg) && out_valid_reg, "waiting item overwritten")
    // active count never exceeds the table size
    `NTA_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, 32'(count_reg) <= TABLE_SLOTS, "active count beyond table size")

endmodule
